/* design/u8u16_pkg.sv */
// ----------------------------------------------------------------------------
// u8u16_pkg
// Shared types and constants for the UTF-8 to UTF-16 newline normaliser.
// ----------------------------------------------------------------------------
package u8u16_pkg;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned UNIT_W  = 16;
   localparam int unsigned POINT_W = 21;
   localparam int unsigned DUE_W   = 2;

   // Result queue: two slots must be free before a byte is taken.
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int unsigned QUEUE_CW    = QUEUE_AW + 1;

   localparam logic [BYTE_W-1:0]  BYTE_LF     = 8'h0a;
   localparam logic [BYTE_W-1:0]  BYTE_CR     = 8'h0d;
   localparam logic [UNIT_W-1:0]  UNIT_LF     = 16'h000a;
   localparam logic [UNIT_W-1:0]  HIGH_BASE   = 16'hd800;
   localparam logic [5:0]         LOW_PREFIX  = 6'b110111;
   localparam logic [POINT_W-1:0] PLANE1_BASE = 21'h010000;

   typedef struct packed {
      logic [POINT_W-1:0] partial_point;
      logic [DUE_W-1:0]   bytes_due;
      logic               after_cr;
   } dec_state_type;

   typedef struct packed {
      logic [1:0]        count;   // units produced by one byte, 0 to 2
      logic [UNIT_W-1:0] unit0;
      logic              last0;
      logic [UNIT_W-1:0] unit1;
   } unit_pair_type;

endpackage

/* design/u8u16_decode.sv */
// ----------------------------------------------------------------------------
// u8u16_decode
// Per-byte decode step: next decoder state and the code units this byte
// produces.
// ----------------------------------------------------------------------------
module u8u16_decode (
   input  u8u16_pkg::dec_state_type          state_cur,
   input  logic [u8u16_pkg::BYTE_W-1:0]      in_byte,
   input  logic                              text_end,
   output u8u16_pkg::dec_state_type          state_nxt,
   output u8u16_pkg::unit_pair_type          units
);

   logic [u8u16_pkg::POINT_W-1:0] point_ext;
   logic [u8u16_pkg::POINT_W-1:0] point_off;
   logic [u8u16_pkg::UNIT_W-1:0]  high_unit;
   logic [u8u16_pkg::UNIT_W-1:0]  low_unit;

   // Append six payload bits of a continuation byte.
   assign point_ext = {state_cur.partial_point[u8u16_pkg::POINT_W-7:0], in_byte[5:0]};
   assign point_off = point_ext - u8u16_pkg::PLANE1_BASE;
   assign high_unit = u8u16_pkg::HIGH_BASE
                    + {5'b0, point_off[u8u16_pkg::POINT_W-1:10]};
   assign low_unit  = {u8u16_pkg::LOW_PREFIX, point_off[9:0]};

   always_comb begin
      state_nxt   = state_cur;
      units.count = 2'd0;
      units.unit0 = '0;
      units.last0 = 1'b1;
      units.unit1 = low_unit;

      if (state_cur.bytes_due != '0) begin
         state_nxt.partial_point = point_ext;
         state_nxt.bytes_due     = state_cur.bytes_due - 1'b1;
         if (state_cur.bytes_due == 2'd1) begin
            if (point_ext[u8u16_pkg::POINT_W-1:u8u16_pkg::UNIT_W] == '0) begin
               units.count = 2'd1;
               units.unit0 = point_ext[u8u16_pkg::UNIT_W-1:0];
            end else begin
               units.count = 2'd2;
               units.unit0 = high_unit;
               units.last0 = 1'b0;
            end
         end
      end else if (state_cur.after_cr && in_byte == u8u16_pkg::BYTE_LF) begin
         // drop the LF of a CR LF pair
         state_nxt.after_cr = 1'b0;
      end else if (in_byte == u8u16_pkg::BYTE_CR) begin
         state_nxt.after_cr = 1'b1;
         units.count        = 2'd1;
         units.unit0        = u8u16_pkg::UNIT_LF;
      end else begin
         state_nxt.after_cr = 1'b0;
         if (!in_byte[7]) begin
            units.count = 2'd1;
            units.unit0 = {8'b0, in_byte};
         end else if (in_byte[7:5] == 3'b110) begin
            state_nxt.partial_point = {16'b0, in_byte[4:0]};
            state_nxt.bytes_due     = 2'd1;
         end else if (in_byte[7:4] == 4'b1110) begin
            state_nxt.partial_point = {17'b0, in_byte[3:0]};
            state_nxt.bytes_due     = 2'd2;
         end else begin
            state_nxt.partial_point = {18'b0, in_byte[2:0]};
            state_nxt.bytes_due     = 2'd3;
         end
      end

      if (text_end) begin
         state_nxt = '0;
      end
   end

endmodule

/* design/u8u16_queue.sv */
// ----------------------------------------------------------------------------
// u8u16_queue
// Small result queue: takes up to two code units per cycle, gives one unless out_stall.
// ----------------------------------------------------------------------------
module u8u16_queue (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              push_valid,
   input  u8u16_pkg::unit_pair_type          push_units,
   output logic                              room_low,
   output logic                              out_valid,
   input  logic                              out_stall,
   output logic [u8u16_pkg::UNIT_W-1:0]      out_unit,
   output logic                              out_last
);

   logic [u8u16_pkg::UNIT_W:0]     slot_ff [u8u16_pkg::QUEUE_DEPTH];
   logic [u8u16_pkg::QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [u8u16_pkg::QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [u8u16_pkg::QUEUE_CW-1:0] count_ff, count_in;
   logic [u8u16_pkg::QUEUE_AW-1:0] wr_next;
   logic [1:0]                     push_n;
   logic                           pop;

   assign push_n  = push_valid ? push_units.count : 2'd0;
   assign pop     = out_valid && !out_stall;
   assign wr_next = u8u16_pkg::QUEUE_AW'(wr_ptr_ff + 1'b1);

   assign out_valid = (count_ff != '0);
   assign out_unit  = slot_ff[rd_ptr_ff][u8u16_pkg::UNIT_W:1];
   assign out_last  = slot_ff[rd_ptr_ff][0];
   // hold off the producer unless two slots are free
   assign room_low  = (count_ff > u8u16_pkg::QUEUE_CW'(u8u16_pkg::QUEUE_DEPTH - 2));

   always_comb begin
      wr_ptr_in = u8u16_pkg::QUEUE_AW'(wr_ptr_ff + push_n);
      rd_ptr_in = pop ? u8u16_pkg::QUEUE_AW'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = u8u16_pkg::QUEUE_CW'(count_ff + push_n - {2'b0, pop});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         slot_ff[wr_ptr_ff] <= {push_units.unit0, push_units.last0};
      end
      if (push_n == 2'd2) begin
         slot_ff[wr_next] <= {push_units.unit1, 1'b1};
      end
   end

endmodule

/* design/utf8_to_utf16_newline_normalizer.sv */
// ----------------------------------------------------------------------------
// utf8_to_utf16_newline_normalizer
// Transcodes a UTF-8 byte stream into UTF-16 code units, turning CR into LF
// and dropping the LF of a CR LF pair.
// ----------------------------------------------------------------------------
//
//  channel  direction  payload                       transfer when
//  req      in         req_in_byte, req_text_end     req_valid && !req_stall
//  rsp      out        rsp_code_unit, rsp_run_last   rsp_valid && !rsp_stall
//
//  One byte per cycle while req_stall is low: each byte is decoded in the
//  cycle it transfers, its zero to two code units land in a four-slot
//  result queue, and a result is registered there before it can leave.
//  req_stall rises while fewer than two queue slots are free, so the input
//  slows only once rsp_stall has let the queue back up; with the consumer
//  always ready the input never stalls.
//  Reset is synchronous, clears the decoder state and empties the queue.
//
module utf8_to_utf16_newline_normalizer (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [u8u16_pkg::BYTE_W-1:0]      req_in_byte,
   input  logic                              req_text_end,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [u8u16_pkg::UNIT_W-1:0]      rsp_code_unit,
   output logic                              rsp_run_last
);

   u8u16_pkg::dec_state_type state_ff, state_in, state_calc;
   u8u16_pkg::unit_pair_type units;
   logic                     req_xfer;
   logic                     room_low;

   assign req_stall = room_low;
   assign req_xfer  = req_valid && !req_stall;

   // Decode the incoming byte against the current partial character.
   u8u16_decode u_decode (
      .state_cur (state_ff),
      .in_byte   (req_in_byte),
      .text_end  (req_text_end),
      .state_nxt (state_calc),
      .units     (units)
   );

   // Advance the decoder state only on an input transfer.
   assign state_in = req_xfer ? state_calc : state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

   // Hold results here until the consumer takes them.
   u8u16_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_xfer),
      .push_units (units),
      .room_low   (room_low),
      .out_valid  (rsp_valid),
      .out_stall  (rsp_stall),
      .out_unit   (rsp_code_unit),
      .out_last   (rsp_run_last)
   );

endmodule

/* design/u8u16_checker.sv */
// ----------------------------------------------------------------------------
// u8u16_checker
// Port-level checks for the UTF-8 to UTF-16 newline normaliser.
// ----------------------------------------------------------------------------
module u8u16_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  logic [u8u16_pkg::BYTE_W-1:0]      req_in_byte,
   input  logic                              req_text_end,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic [u8u16_pkg::UNIT_W-1:0]      rsp_code_unit,
   input  logic                              rsp_run_last
);

   logic rsp_xfer;
   assign rsp_xfer = rsp_valid && !rsp_stall;

   // a stalled byte holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_in_byte)
                                 && $stable(req_text_end))
      else $error("stalled byte changed");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_code_unit)
                                 && $stable(rsp_run_last))
      else $error("stalled result changed");

   // no result straight out of reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a non-final unit is always in the surrogate range
   a_high_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_run_last |-> rsp_code_unit[15:11] == 5'b11011)
      else $error("non-final unit is not a high surrogate");

   // a low surrogate follows its high half at once
   a_pair_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_xfer && !rsp_run_last |=> rsp_valid && rsp_run_last
                                    && rsp_code_unit[15:10] == 6'b110111)
      else $error("high surrogate not followed by low surrogate");

endmodule

bind utf8_to_utf16_newline_normalizer u8u16_checker u_checker (.*);
